[src/wavetable_voice_with_ar_envelope_unit_defines.svh]
// Assertion helpers used by the checker file of this block.
`ifndef WAVETABLE_VOICE_WITH_AR_ENVELOPE_UNIT_DEFINES_SVH
`define WAVETABLE_VOICE_WITH_AR_ENVELOPE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WTV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define WTV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/wtv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wtv_pkg;

  // table geometry (TABLE_SIZE must be a power of two)
  localparam int TABLE_SIZE          = 1024;
  localparam int PHASE_FRACTION_BITS = 16;
  localparam int TBL_AW              = $clog2(TABLE_SIZE);
  localparam int BANK_COUNT          = 3;
  localparam int WAVE_DEPTH          = BANK_COUNT * TABLE_SIZE;
  localparam int WAVE_AW             = TBL_AW + 2;
  localparam int PHASE_W             = TBL_AW + PHASE_FRACTION_BITS;

  // field widths
  localparam int OP_W       = 2;
  localparam int NOTE_W     = 7;
  localparam int CHOICE_W   = 2;
  localparam int ADDR_W     = 10;
  localparam int SMP_W      = 16;
  localparam int MIX_W      = 24;
  localparam int INC_W      = 26;
  localparam int ENV_W      = 25;
  localparam int GAIN_W     = 17;
  localparam int SEL_W      = 2;
  localparam int VOICE_W    = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 26;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  localparam logic [ENV_W-1:0] ENV_ONE  = 25'h100_0000;
  localparam logic [INC_W-1:0] STEP_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_NOTE_ON  = 2'd1,
    OP_NOTE_OFF = 2'd2,
    OP_LOAD     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    BANK_SINE = 2'd0,
    BANK_SAW  = 2'd1,
    BANK_TRI  = 2'd2,
    BANK_NONE = 2'd3
  } bank_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_ATTACK  = 2'd1,
    ST_SUSTAIN = 2'd2,
    ST_RELEASE = 2'd3
  } env_stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_INC = 3'd0,
    CFG_ATTACK   = 3'd1,
    CFG_RELEASE  = 3'd2,
    CFG_GAIN     = 3'd3,
    CFG_WAVE_SEL = 3'd4
  } cfg_idx_t;

  // strobes from the sequencer into the voice state
  typedef struct packed {
    logic tick;
    logic note_on;
    logic note_off;
    logic step_load;
  } voice_ctrl_t;

  // strobes from the sequencer into the sample datapath
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic mul3;
  } smp_ctrl_t;

  // octave = d / 12 for d below 132
  function automatic logic [3:0] note_octave(input logic [7:0] d);
    logic [3:0] oct;
    oct = '0;
    for (int k = 1; k <= 10; k++) begin
      if (d >= 8'(12 * k)) oct = oct + 4'd1;
    end
    return oct;
  endfunction

  // 2^(k/12) in Q16
  function automatic logic [16:0] semitone_ratio(input logic [3:0] s);
    logic [16:0] r;
    case (s)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd69433;
      4'd2:    r = 17'd73562;
      4'd3:    r = 17'd77936;
      4'd4:    r = 17'd82570;
      4'd5:    r = 17'd87480;
      4'd6:    r = 17'd92682;
      4'd7:    r = 17'd98193;
      4'd8:    r = 17'd104032;
      4'd9:    r = 17'd110218;
      4'd10:   r = 17'd116772;
      4'd11:   r = 17'd123715;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[src/wtv_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[src/wtv_voice.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtv_voice (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wtv_pkg::voice_ctrl_t           ctrl,
  input  wire logic [wtv_pkg::NOTE_W-1:0]     note_number,
  input  wire logic [wtv_pkg::INC_W-1:0]      base_increment,
  input  wire logic [wtv_pkg::ENV_W-1:0]      attack_step,
  input  wire logic [wtv_pkg::ENV_W-1:0]      release_step,
  output logic      [wtv_pkg::PHASE_W-1:0]    phase,
  output wtv_pkg::env_stage_t                 stage,
  output logic      [wtv_pkg::ENV_W-1:0]      env_level
);
  import wtv_pkg::*;

  logic [PHASE_W-1:0] phase_r;
  logic [INC_W-1:0]   step_r;
  logic [ENV_W-1:0]   env_r;
  env_stage_t         stage_r;

  // note-to-increment: product registered, then round and saturate
  logic [42:0]        prod_r;
  logic [4:0]         shift_r;

  logic [7:0]         note_d;
  logic [3:0]         oct;
  logic [7:0]         semi_full;
  logic [16:0]        ratio;
  logic [43:0]        half;
  logic [43:0]        rnd;
  logic [INC_W-1:0]   step_rnd;

  logic [ENV_W:0]     att_sum;
  logic [ENV_W-1:0]   env_tick;
  env_stage_t         stage_tick;

  assign note_d    = {1'b0, note_number} + 8'd3;
  assign oct       = note_octave(note_d);
  assign semi_full = note_d - 8'({4'd0, oct} * 8'd12);
  assign ratio     = semitone_ratio(semi_full[3:0]);

  assign half     = 44'd1 << (shift_r - 5'd1);
  assign rnd      = ({1'b0, prod_r} + half) >> shift_r;
  assign step_rnd = (rnd > 44'(STEP_MAX)) ? STEP_MAX : rnd[INC_W-1:0];

  // one envelope step
  always_comb begin
    att_sum    = {1'b0, env_r} + {1'b0, attack_step};
    env_tick   = env_r;
    stage_tick = stage_r;
    unique case (stage_r)
      ST_ATTACK: begin
        if (att_sum >= {1'b0, ENV_ONE}) begin
          env_tick   = ENV_ONE;
          stage_tick = ST_SUSTAIN;
        end else begin
          env_tick = att_sum[ENV_W-1:0];
        end
      end
      ST_RELEASE: begin
        if (release_step != '0 && env_r <= release_step) begin
          env_tick   = '0;
          stage_tick = ST_IDLE;
        end else begin
          env_tick = env_r - release_step;
        end
      end
      ST_IDLE, ST_SUSTAIN: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      step_r  <= '0;
      env_r   <= '0;
      stage_r <= ST_IDLE;
    end else begin
      if (ctrl.note_on) begin
        phase_r <= '0;
        env_r   <= '0;
        stage_r <= ST_ATTACK;
      end else if (ctrl.note_off) begin
        if (stage_r != ST_IDLE) stage_r <= ST_RELEASE;
      end else if (ctrl.tick) begin
        if (stage_r != ST_IDLE) begin
          env_r   <= env_tick;
          stage_r <= stage_tick;
          // modulo table length is the natural wrap of the accumulator
          phase_r <= PHASE_W'(phase_r + PHASE_W'(step_r));
        end
      end
      if (ctrl.step_load) step_r <= step_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.note_on) begin
      prod_r  <= base_increment * ratio;
      shift_r <= 5'd22 - {1'b0, oct};
    end
  end

  assign phase     = phase_r;
  assign stage     = stage_r;
  assign env_level = env_r;

endmodule

`default_nettype wire

[src/wtv_sample.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtv_sample (
  input  wire logic                                    clk,
  input  wire wtv_pkg::smp_ctrl_t                      ctrl,
  input  wire logic [wtv_pkg::PHASE_FRACTION_BITS-1:0] frac,
  input  wire logic signed [wtv_pkg::SMP_W-1:0]        smp_a,
  input  wire logic signed [wtv_pkg::SMP_W-1:0]        smp_b,
  input  wire logic [wtv_pkg::ENV_W-1:0]               env_level,
  input  wire logic [wtv_pkg::GAIN_W-1:0]              gain,
  output logic signed [wtv_pkg::VOICE_W-1:0]           voice
);
  import wtv_pkg::*;

  localparam int F     = PHASE_FRACTION_BITS;
  localparam int P1_W  = (SMP_W + 1) + (F + 1);
  localparam int IW    = P1_W + 1;
  localparam int RSH   = F - 8;
  localparam int S23_W = 25;
  localparam int P2_W  = S23_W + ENV_W + 1;
  localparam int EN_W  = 25;
  localparam int P3_W  = EN_W + GAIN_W + 1;

  localparam logic signed [IW-1:0]   RND1 = (IW'(1) << RSH) >> 1;
  localparam logic signed [P2_W-1:0] RND2 = P2_W'(1) << 23;
  localparam logic signed [P3_W-1:0] RND3 = P3_W'(1) << 16;

  logic [F-1:0]              frac_r;
  logic signed [SMP_W-1:0]   a_r;
  logic signed [P1_W-1:0]    prod1_r;
  logic signed [P2_W-1:0]    prod2_r;
  logic signed [P3_W-1:0]    prod3_r;

  logic signed [SMP_W:0]     diff;
  logic signed [F:0]         frac_s;
  logic signed [IW-1:0]      interp;
  logic signed [S23_W-1:0]   s23;
  logic signed [ENV_W:0]     env_s;
  logic signed [EN_W-1:0]    enved;
  logic signed [GAIN_W:0]    gain_s;

  assign diff   = {smp_b[SMP_W-1], smp_b} - {smp_a[SMP_W-1], smp_a};
  assign frac_s = {1'b0, frac_r};
  assign interp = (IW'(a_r) <<< F) + IW'(prod1_r);
  assign s23    = S23_W'((interp + RND1) >>> RSH);
  assign env_s  = {1'b0, env_level};
  assign enved  = EN_W'((prod2_r + RND2) >>> 24);
  assign gain_s = {1'b0, gain};
  // Q16 gain and the halving, rounded together
  assign voice  = VOICE_W'((prod3_r + RND3) >>> 17);

  always_ff @(posedge clk) begin
    if (ctrl.capture) frac_r <= frac;
    if (ctrl.mul1) begin
      a_r     <= smp_a;
      prod1_r <= diff * frac_s;
    end
    if (ctrl.mul2) prod2_r <= s23 * env_s;
    if (ctrl.mul3) prod3_r <= enved * gain_s;
  end

endmodule

`default_nettype wire

[src/wavetable_voice_with_ar_envelope_unit.sv]
// One wavetable synth voice with a linear attack/release envelope. Each input
// transaction carries an operation in in_tuser: sample tick, note on, note
// off, or load of one table word. Table loads write one entry of the sine,
// saw or triangle bank in a 3 x 1024 word RAM; the RAM has no reset and no
// clearing pass, so software loads every table entry it will play before the
// first note. Note on restarts the phase and the envelope and derives the
// phase increment from the note number (registered product, then round and
// saturate). Every tick yields exactly one result transaction: mix_in plus
// the voice sample, saturated to 24 bits, the active flag and the envelope
// level after the tick. A tick on a sounding voice holds off the next
// transaction while it runs: the two adjacent table words are read in the
// accept cycle, then three chained multiplies (interpolation, envelope, gain)
// run one per cycle and the output state rounds, mixes and saturates into the
// output register. A tick on an idle voice passes mix_in through. The output
// register holds one finished result, so a new item is taken while it waits;
// the block only stalls when a second result is ready before the first is
// taken. Configuration registers are to be written only while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_voice_with_ar_envelope_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // tdata: note_number[6:0], table_choice[8:7], table_address[18:9],
  //        table_word[34:19], mix_in[58:35], zero fill [63:59]
  input  wire logic [wtv_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: operation[1:0]
  input  wire logic [wtv_pkg::OP_W-1:0]          in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // tdata: mix_out[23:0], voice_active[24], envelope_level[49:25],
  //        zero fill [55:50]
  output logic      [wtv_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [wtv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [wtv_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import wtv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_NOTE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_OUT
  } state_t;

  localparam logic signed [MIX_W+2:0] MIX_MAX = 27'sd8388607;
  localparam logic signed [MIX_W+2:0] MIX_MIN = -27'sd8388608;

  state_t state_r;

  // configuration registers
  logic [INC_W-1:0]  base_inc_r;
  logic [ENV_W-1:0]  attack_r;
  logic [ENV_W-1:0]  release_r;
  logic [GAIN_W-1:0] gain_r;
  logic [SEL_W-1:0]  wave_sel_r;

  // tick context and output register
  logic signed [MIX_W-1:0] mix_r;
  logic                    sound_r;
  logic                    out_valid_r;
  logic [OUT_TDATA_W-1:0]  out_data_r;

  // unpacked input fields
  op_t                     op;
  logic [NOTE_W-1:0]       in_note;
  logic [CHOICE_W-1:0]     in_choice;
  logic [ADDR_W-1:0]       in_addr;
  logic [SMP_W-1:0]        in_word;
  logic signed [MIX_W-1:0] in_mix;

  logic                    accept;
  logic                    load_ok;
  logic                    out_fire;
  voice_ctrl_t             vctrl;
  smp_ctrl_t               sctrl;

  logic [PHASE_W-1:0]      phase;
  env_stage_t              stage;
  logic [ENV_W-1:0]        env_level;

  logic [1:0]              bank;
  logic [TBL_AW-1:0]       idx;
  logic [TBL_AW-1:0]       idx_next;
  logic [SMP_W-1:0]        rdata_a;
  logic [SMP_W-1:0]        rdata_b;

  logic signed [VOICE_W-1:0] voice;
  logic signed [VOICE_W-1:0] voice_g;
  logic signed [MIX_W+2:0]   mix_sum;
  logic signed [MIX_W-1:0]   mix_sat;
  logic [OUT_TDATA_W-1:0]    out_word;

  assign op        = op_t'(in_tuser);
  assign in_note   = in_tdata[6:0];
  assign in_choice = in_tdata[8:7];
  assign in_addr   = in_tdata[18:9];
  assign in_word   = in_tdata[34:19];
  assign in_mix    = in_tdata[58:35];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // unused bank code and out-of-range addresses drop the load
  assign load_ok = (in_choice != BANK_NONE) && (32'(in_addr) < 32'(TABLE_SIZE));

  assign vctrl.tick      = accept && (op == OP_TICK);
  assign vctrl.note_on   = accept && (op == OP_NOTE_ON);
  assign vctrl.note_off  = accept && (op == OP_NOTE_OFF);
  assign vctrl.step_load = (state_r == S_NOTE);

  assign sctrl.capture = vctrl.tick;
  assign sctrl.mul1    = (state_r == S_MUL1);
  assign sctrl.mul2    = (state_r == S_MUL2);
  assign sctrl.mul3    = (state_r == S_MUL3);

  // select 3 falls back to the sine bank
  assign bank = (wave_sel_r == BANK_SAW) ? BANK_SAW :
                (wave_sel_r == BANK_TRI) ? BANK_TRI : BANK_SINE;
  assign idx      = phase[PHASE_W-1 -: TBL_AW];
  assign idx_next = TBL_AW'(idx + 1'b1);

  wtv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (WAVE_DEPTH)
  ) u_wave_ram (
    .clk     (clk),
    .we      (accept && (op == OP_LOAD) && load_ok),
    .waddr   ({in_choice, in_addr[TBL_AW-1:0]}),
    .wdata   (in_word),
    .re      (vctrl.tick),
    .raddr_a ({bank, idx}),
    .raddr_b ({bank, idx_next}),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  wtv_voice u_voice (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (vctrl),
    .note_number    (in_note),
    .base_increment (base_inc_r),
    .attack_step    (attack_r),
    .release_step   (release_r),
    .phase          (phase),
    .stage          (stage),
    .env_level      (env_level)
  );

  wtv_sample u_sample (
    .clk       (clk),
    .ctrl      (sctrl),
    .frac      (phase[PHASE_FRACTION_BITS-1:0]),
    .smp_a     (rdata_a),
    .smp_b     (rdata_b),
    .env_level (env_level),
    .gain      (gain_r),
    .voice     (voice)
  );

  // mix and saturate; an idle tick adds nothing
  assign voice_g = sound_r ? voice : '0;
  assign mix_sum = (MIX_W+3)'(mix_r) + (MIX_W+3)'(voice_g);
  always_comb begin
    priority if (mix_sum > MIX_MAX) mix_sat = MIX_MAX[MIX_W-1:0];
    else if (mix_sum < MIX_MIN)     mix_sat = MIX_MIN[MIX_W-1:0];
    else                            mix_sat = mix_sum[MIX_W-1:0];
  end

  assign out_word = {(OUT_TDATA_W-MIX_W-1-ENV_W)'(0), env_level,
                     (stage != ST_IDLE), mix_sat};

  assign out_fire = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_inc_r <= INC_W'(615164);
      attack_r   <= ENV_W'(34953);
      release_r  <= ENV_W'(3495);
      gain_r     <= GAIN_W'(65536);
      wave_sel_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_INC: base_inc_r <= cfg_wdata[INC_W-1:0];
        CFG_ATTACK:   attack_r   <= cfg_wdata[ENV_W-1:0];
        CFG_RELEASE:  release_r  <= cfg_wdata[ENV_W-1:0];
        CFG_GAIN:     gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_WAVE_SEL: wave_sel_r <= cfg_wdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (vctrl.tick) begin
      mix_r   <= in_mix;
      sound_r <= (stage != ST_IDLE);
    end
    if (out_fire) out_data_r <= out_word;

    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a new result replaces the one taken in the same cycle
      if (out_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (vctrl.tick) begin
            state_r <= (stage != ST_IDLE) ? S_MUL1 : S_OUT;
          end else if (vctrl.note_on) begin
            state_r <= S_NOTE;
          end
        end
        S_NOTE: state_r <= S_IDLE;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= S_MUL3;
        S_MUL3: state_r <= S_OUT;
        S_OUT: begin
          if (out_fire) state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[src/wtv_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "wavetable_voice_with_ar_envelope_unit_defines.svh"

module wtv_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic [wtv_pkg::OP_W-1:0]        in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [wtv_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import wtv_pkg::*;

  `WTV_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped or changed while stalled")

  `WTV_ASSERT_NXT(a_tick_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == OP_TICK, !in_tready, "tick did not occupy the sequencer")

  `WTV_ASSERT_IMP(a_idle_env_zero, clk, rst_n, out_tvalid && !out_tdata[24], out_tdata[49:25] == '0, "idle voice reports nonzero envelope")

  `WTV_ASSERT_IMP(a_env_max, clk, rst_n, out_tvalid, out_tdata[49:25] <= ENV_ONE, "envelope above one")

endmodule

bind wavetable_voice_with_ar_envelope_unit wtv_checker u_wtv_checker (.*);

`default_nettype wire

[sim/wavetable_voice_with_ar_envelope_unit_test.sv]
`timescale 1ns / 1ps

module wavetable_voice_with_ar_envelope_unit_test;
  import wtv_pkg::*;

  // Watchdog: cycles in a row with no transaction on any port. The slowest
  // correct item is far shorter than the one long output hold-off, which is
  // HOLD_CYCLES, so this limit is several times the worst legal quiet run.
  localparam int     STALL_LIMIT     = 3000;
  localparam int     HOLD_CYCLES     = 400;
  localparam int     ITEMS_PER_PHASE = 90;
  localparam int     SETTLE_CYCLES   = 12;   // note on may still be computing its increment
  localparam longint ENV_FULL        = 64'sd1 << 24;
  localparam longint INC_CAP         = (64'sd1 << INC_W) - 1;
  localparam longint PHASE_MASK      = (64'sd1 << PHASE_W) - 1;
  localparam longint MIX_HI          = 64'sd8388607;
  localparam longint MIX_LO          = -64'sd8388608;

  typedef struct packed {
    op_t                     op;
    logic [NOTE_W-1:0]       note;
    logic [CHOICE_W-1:0]     choice;
    logic [ADDR_W-1:0]       addr;
    logic signed [SMP_W-1:0] word;
    logic signed [MIX_W-1:0] mix;
  } voice_item_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix;
    logic                    active;
    logic [ENV_W-1:0]        level;
  } voice_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  wavetable_voice_with_ar_envelope_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Voice predictor state: register copies (reset values) and voice state
  // ---------------------------------------------------------------------------
  longint base_inc_q16 = 615164;
  longint attack_rate  = 34953;
  longint release_rate = 3495;
  longint gain_q16     = 65536;
  longint wave_sel     = 0;

  longint     voice_phase = 0;
  longint     voice_inc   = 0;
  longint     env_level   = 0;
  env_stage_t env_stage   = ST_IDLE;
  logic signed [SMP_W-1:0] wave_mem [0:WAVE_DEPTH-1];

  // generation-side copy of the voice: tells which table entries a queued
  // tick will read, so each one is loaded just before its first read
  longint     gen_phase = 0;
  longint     gen_inc   = 0;
  longint     gen_level = 0;
  env_stage_t gen_stage = ST_IDLE;
  bit         wave_written [0:WAVE_DEPTH-1];

  // equal-tempered semitone ratios, Q16
  longint semitone_q16 [0:11] = '{65536, 69433, 73562, 77936, 82570, 87480,
                                  92682, 98193, 104032, 110218, 116772, 123715};

  voice_item_t   note_stream_q[$];        // items waiting for the feeder
  voice_result_t pending_mix_results[$];  // predicted tick results, oldest first

  int unsigned errors          = 0;
  int unsigned items_taken     = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;
  int unsigned queued_items    = 0;
  int          stall_cycles    = 0;

  logic in_acc  = 1'b0;   // input transaction at the last rising edge
  logic out_acc = 1'b0;   // result transaction at the last rising edge
  logic rx_hold = 1'b0;   // long output hold-off in progress
  int   tx_gap  = 0;
  int   rx_wait = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;

  // Phase increment for a MIDI note: semitone ratio times base, shifted by octave with rounding, saturated.
  function automatic longint note_increment(input logic [NOTE_W-1:0] note);
    int     d;
    int     sh;
    longint prod;
    longint inc;
    d    = int'(note) + 3;
    sh   = 22 - d / 12;
    prod = base_inc_q16 * semitone_q16[d % 12];
    inc  = (prod + (64'sd1 << (sh - 1))) >> sh;
    return (inc > INC_CAP) ? INC_CAP : inc;
  endfunction

  // One envelope step of a sounding voice.
  function automatic void env_step(inout longint lvl, inout env_stage_t st);
    case (st)
      ST_ATTACK: begin
        lvl += attack_rate;
        if (lvl >= ENV_FULL) begin
          lvl = ENV_FULL;
          st  = ST_SUSTAIN;
        end
      end
      ST_RELEASE: begin
        if (release_rate != 0 && lvl <= release_rate) begin
          lvl = 0;
          st  = ST_IDLE;
        end else begin
          lvl -= release_rate;
        end
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted item to the voice; a tick queues its expected result.
  task automatic voice_render(input voice_item_t it);
    longint        mix_acc;
    longint        a;
    longint        b;
    longint        frac;
    longint        interp;
    longint        s23;
    longint        enved;
    int            bank_ofs;
    int            idx;
    voice_result_t res;
    case (it.op)
      OP_NOTE_ON: begin
        voice_phase = 0;
        voice_inc   = note_increment(it.note);
        env_level   = 0;
        env_stage   = ST_ATTACK;
      end
      OP_NOTE_OFF: begin
        if (env_stage != ST_IDLE) env_stage = ST_RELEASE;
      end
      OP_LOAD: begin
        // unused bank code drops the write
        if (bank_t'(it.choice) != BANK_NONE)
          wave_mem[int'(it.choice) * TABLE_SIZE + int'(it.addr)] = it.word;
      end
      default: begin
        mix_acc = $signed(it.mix);
        if (env_stage != ST_IDLE) begin
          // envelope moves first, the sample uses the new level
          env_step(env_level, env_stage);
          bank_ofs = (wave_sel == 1) ? TABLE_SIZE : (wave_sel == 2) ? 2 * TABLE_SIZE : 0;
          idx      = int'(voice_phase >> PHASE_FRACTION_BITS);
          frac     = voice_phase & ((64'sd1 << PHASE_FRACTION_BITS) - 1);
          a        = wave_mem[bank_ofs + idx];
          b        = wave_mem[bank_ofs + (idx + 1) % TABLE_SIZE];
          // exact interpolation, then round half up at each narrowing
          interp   = (a <<< PHASE_FRACTION_BITS) + (b - a) * frac;
          s23      = (interp + (64'sd1 <<< (PHASE_FRACTION_BITS - 9))) >>> (PHASE_FRACTION_BITS - 8);
          enved    = (s23 * env_level + (64'sd1 <<< 23)) >>> 24;
          mix_acc += (enved * gain_q16 + (64'sd1 <<< 16)) >>> 17;  // gain Q16 plus the halving
          if (mix_acc > MIX_HI) mix_acc = MIX_HI;
          if (mix_acc < MIX_LO) mix_acc = MIX_LO;
          voice_phase = (voice_phase + voice_inc) & PHASE_MASK;
        end
        res.mix    = mix_acc[MIX_W-1:0];
        res.active = (env_stage != ST_IDLE);
        res.level  = env_level[ENV_W-1:0];
        pending_mix_results.push_back(res);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge; check results first,
  // since a result never belongs to the item taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    voice_item_t             taken;
    voice_result_t           want;
    logic signed [MIX_W-1:0] got_mix;
    logic                    got_active;
    logic [ENV_W-1:0]        got_level;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_mix    = out_tdata[23:0];
        got_active = out_tdata[24];
        got_level  = out_tdata[49:25];
        results_checked++;
        if (pending_mix_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: mix_out %0d active %0b envelope %0d",
                   $time, got_mix, got_active, got_level);
        end else begin
          want = pending_mix_results.pop_front();
          if (got_mix !== want.mix) begin
            errors++;
            $display("%0t: mix_out expected %0d, got %0d", $time, $signed(want.mix), got_mix);
          end
          if (got_active !== want.active) begin
            errors++;
            $display("%0t: voice_active expected %0b, got %0b", $time, want.active, got_active);
          end
          if (got_level !== want.level) begin
            errors++;
            $display("%0t: envelope_level expected %0d, got %0d", $time, want.level, got_level);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        taken.op     = op_t'(in_tuser);
        taken.note   = in_tdata[6:0];
        taken.choice = in_tdata[8:7];
        taken.addr   = in_tdata[18:9];
        taken.word   = in_tdata[34:19];
        taken.mix    = in_tdata[58:35];
        voice_render(taken);
        items_taken++;
      end
    end
    in_acc  <= rst_n && in_tvalid && in_tready;
    out_acc <= rst_n && out_tvalid && out_tready;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Feeder: drives the input channel at the falling edge. Each item draws its
  // own gap; burst mode gives stretches with no gaps at all.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : feeder
    voice_item_t head;
    logic        offer;
    offer = in_tvalid;
    if (in_acc) offer = 1'b0;
    if (rst_n && !offer) begin
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (note_stream_q.size() != 0) begin
        head      = note_stream_q.pop_front();
        in_tuser <= head.op;
        in_tdata <= {5'b0, head.mix, head.word, head.addr, head.choice, head.note};
        offer     = 1'b1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_gap = tx_burst ? 0 : $urandom_range(0, 11);
      end
    end
    in_tvalid <= offer;
  end

  // Result side: a fresh random stall after every result (none in burst mode),
  // counted whether or not the next one is already waiting.
  always @(negedge clk) begin : drain
    if (out_acc) begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 11);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_tready <= (rx_wait == 0) && !rx_hold;
  end

  // One long hold-off on the result side while ticks keep coming, so the
  // output register fills and the block has to stall its input.
  initial begin : rx_pressure
    wait (results_checked >= 150);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("wavetable_voice_with_ar_envelope_unit_test: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [MIX_W-1:0] pick_mix();
    case ($urandom_range(0, 7))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      default: return MIX_W'($urandom());
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  // queue a load for a table entry that has never been written
  task automatic fill_entry(input int bank_ofs, input int idx);
    voice_item_t ld;
    if (!wave_written[bank_ofs + idx]) begin
      ld.op     = OP_LOAD;
      ld.note   = NOTE_W'($urandom());
      ld.choice = CHOICE_W'(bank_ofs / TABLE_SIZE);
      ld.addr   = ADDR_W'(idx);
      ld.word   = pick_word();
      ld.mix    = pick_mix();
      note_stream_q.push_back(ld);
      queued_items++;
      wave_written[bank_ofs + idx] = 1'b1;
    end
  endtask

  task automatic queue_item(input op_t op, input logic [NOTE_W-1:0] note,
                            input logic [CHOICE_W-1:0] choice, input logic [ADDR_W-1:0] addr,
                            input logic [SMP_W-1:0] word, input logic [MIX_W-1:0] mix);
    voice_item_t it;
    int          bank_ofs;
    int          idx;
    it.op     = op;
    it.note   = note;
    it.choice = choice;
    it.addr   = addr;
    it.word   = word;
    it.mix    = mix;
    case (op)
      OP_NOTE_ON: begin
        gen_phase = 0;
        gen_inc   = note_increment(note);
        gen_level = 0;
        gen_stage = ST_ATTACK;
      end
      OP_NOTE_OFF: begin
        if (gen_stage != ST_IDLE) gen_stage = ST_RELEASE;
      end
      OP_LOAD: begin
        if (bank_t'(choice) != BANK_NONE)
          wave_written[int'(choice) * TABLE_SIZE + int'(addr)] = 1'b1;
      end
      default: begin
        if (gen_stage != ST_IDLE) begin
          env_step(gen_level, gen_stage);
          bank_ofs = (wave_sel == 1) ? TABLE_SIZE : (wave_sel == 2) ? 2 * TABLE_SIZE : 0;
          idx      = int'(gen_phase >> PHASE_FRACTION_BITS);
          fill_entry(bank_ofs, idx);
          fill_entry(bank_ofs, (idx + 1) % TABLE_SIZE);
          gen_phase = (gen_phase + gen_inc) & PHASE_MASK;
        end
      end
    endcase
    note_stream_q.push_back(it);
    queued_items++;
  endtask

  // fields the operation does not use are random too
  task automatic queue_random(input op_t op);
    queue_item(op, NOTE_W'($urandom()), CHOICE_W'($urandom()), ADDR_W'($urandom()),
               SMP_W'($urandom()), pick_mix());
  endtask

  // note on, held ticks, usually a note off, release ticks, some noise
  task automatic queue_note_sequence();
    int hold;
    queue_random(OP_NOTE_ON);
    hold = $urandom_range(1, 40);
    repeat (hold) queue_random(OP_TICK);
    if ($urandom_range(0, 3) != 0) queue_random(OP_NOTE_OFF);
    hold = $urandom_range(0, 40);
    repeat (hold) queue_random(OP_TICK);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0:       queue_random(OP_LOAD);   // writes a random entry, or goes to the unused bank
        1:       queue_random(OP_NOTE_OFF);
        default: queue_random(OP_TICK);
      endcase
    end
  endtask

  task automatic wait_drained();
    while (note_stream_q.size() != 0 || in_tvalid || pending_mix_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input longint value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_BASE_INC: base_inc_q16 = value & ((64'sd1 << INC_W) - 1);
      CFG_ATTACK:   attack_rate  = value & ((64'sd1 << ENV_W) - 1);
      CFG_RELEASE:  release_rate = value & ((64'sd1 << ENV_W) - 1);
      CFG_GAIN:     gain_q16     = value & ((64'sd1 << GAIN_W) - 1);
      default:      wave_sel     = value & ((64'sd1 << SEL_W) - 1);
    endcase
  endtask

  // registers change only with nothing in flight
  task automatic apply_settings(input longint base_inc, input longint rise, input longint fall,
                                input longint gain, input longint sel);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_BASE_INC, base_inc);
    write_reg(CFG_ATTACK, rise);
    write_reg(CFG_RELEASE, fall);
    write_reg(CFG_GAIN, gain);
    write_reg(CFG_WAVE_SEL, sel);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase_start;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle voice passes the mix through, extremes included
    queue_item(OP_TICK, 7'h00, 2'h0, 10'h000, 16'h0000, 24'h000000);
    queue_item(OP_TICK, 7'h7F, 2'h3, 10'h3FF, 16'hFFFF, 24'h7FFFFF);
    queue_item(OP_TICK, 7'h55, 2'h1, 10'h2AA, 16'h5555, 24'h800000);
    queue_item(OP_NOTE_OFF, 7'h2A, 2'h2, 10'h155, 16'hAAAA, 24'h555555);  // nothing playing
    queue_item(OP_LOAD, 7'h00, BANK_NONE, 10'h3FF, 16'h7FFF, 24'h000000);  // dropped

    // table entries are loaded on demand, just ahead of the first tick that reads them

    // lowest and highest note, restart mid-note, note off in attack and in release
    queue_item(OP_NOTE_ON, 7'd0, CHOICE_W'($urandom()), ADDR_W'($urandom()),
               SMP_W'($urandom()), MIX_W'($urandom()));
    queue_item(OP_TICK, NOTE_W'($urandom()), CHOICE_W'($urandom()), ADDR_W'($urandom()),
               SMP_W'($urandom()), 24'h7FFFFF);
    queue_item(OP_TICK, NOTE_W'($urandom()), CHOICE_W'($urandom()), ADDR_W'($urandom()),
               SMP_W'($urandom()), 24'h800000);
    queue_random(OP_TICK);
    queue_item(OP_NOTE_ON, 7'd127, CHOICE_W'($urandom()), ADDR_W'($urandom()),
               SMP_W'($urandom()), MIX_W'($urandom()));
    repeat (2) queue_random(OP_TICK);
    queue_random(OP_NOTE_OFF);
    repeat (3) queue_random(OP_TICK);
    queue_random(OP_NOTE_OFF);
    repeat (4) queue_random(OP_TICK);

    // register settings: extremes and step corner cases first, then random ones
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        // full step both ways: jump to sustain, drop to idle in one tick
        0: apply_settings(615164, 64'd1 << 24, 64'd1 << 24, 65536, 1);
        // widest base saturates the increment, slowest envelope, gain zero
        1: apply_settings(INC_CAP, 1, 1, 0, 2);
        // phase frozen; steps above one saturate / end at zero; select 3 reads sine
        2: apply_settings(0, (64'd1 << ENV_W) - 1, (64'd1 << ENV_W) - 1, 65536, 3);
        // attack step zero holds the envelope at zero
        3: apply_settings($urandom_range(0, 67108863), 0, 64'd1 << 20,
                          $urandom_range(0, 65536), 0);
        // release step zero holds the level in release
        4: apply_settings($urandom_range(0, 67108863), 64'd1 << 22, 0, 65536, 2);
        default: apply_settings($urandom_range(0, 67108863), $urandom_range(1 << 18, 1 << 24),
                                $urandom_range(1 << 18, 1 << 24), $urandom_range(0, 65536),
                                $urandom_range(0, 3));
      endcase
      phase_start = queued_items;
      while (queued_items - phase_start < ITEMS_PER_PHASE) queue_note_sequence();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("run: %0d input transactions, %0d tick results checked, %0d register settings",
             items_taken, results_checked, settings_used + 1);
    $display("run: all three banks read, notes and restarts, zero and over-range steps, "
             , "gain zero to unity, mix saturation, output back-pressure");
    if (errors == 0 && pending_mix_results.size() == 0) begin
      $display("wavetable_voice_with_ar_envelope_unit_test: PASS");
    end else begin
      $display("wavetable_voice_with_ar_envelope_unit_test: FAIL");
    end
    $finish;
  end

endmodule

[wavetable_voice_with_ar_envelope_unit.f]
+incdir+src
src/wtv_pkg.sv
src/wtv_ram.sv
src/wtv_voice.sv
src/wtv_sample.sv
src/wavetable_voice_with_ar_envelope_unit.sv
src/wtv_checker.sv
sim/wavetable_voice_with_ar_envelope_unit_test.sv
